>>> rtl/lbhs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbhs_pkg
// Shared types and constants for the LOD band hysteresis selector.
// ----------------------------------------------------------------------------
package lbhs_pkg;

  // Band ladder limits
  localparam int MAX_BANDS = 4;
  localparam int BAND_CAP  = (MAX_BANDS < 4) ? MAX_BANDS : 4;

  // Q1.16 one
  localparam logic [16:0] HYST_ONE = 17'd65536;

  // Command codes
  localparam logic [1:0] CMD_UPDATE = 2'd0;
  localparam logic [1:0] CMD_CLEAR  = 2'd1;
  localparam logic [1:0] CMD_FORCE  = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_BAND_COUNT = 3'd0;
  localparam logic [2:0] REG_THRESH0    = 3'd1;
  localparam logic [2:0] REG_THRESH1    = 3'd2;
  localparam logic [2:0] REG_THRESH2    = 3'd3;
  localparam logic [2:0] REG_HYST       = 3'd4;
  localparam logic [2:0] REG_DWELL      = 3'd5;

  // Input beat
  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] quality_metric;
    logic [1:0]         regime_floor;
    logic [1:0]         forced_band;
  } in_item_t;

  // Result beat
  typedef struct packed {
    logic [1:0]  band_index;
    logic        band_changed;
    logic [30:0] clamped_quality;
  } out_item_t;

  // Configuration register set
  typedef struct packed {
    logic [2:0]  band_count;
    logic [31:0] threshold_band0;
    logic [31:0] threshold_band1;
    logic [31:0] threshold_band2;
    logic [16:0] hysteresis_fraction;
    logic [7:0]  dwell_frames;
  } cfg_t;

  // Selector state
  typedef struct packed {
    logic [1:0] current_band;
    logic [1:0] pending_band;
    logic [7:0] pending_count;
    logic       initialized;
  } sel_state_t;

endpackage

>>> rtl/lbhs_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbhs_cfg_regs
// Configuration register file, write-only, reset to the default ladder.
// ----------------------------------------------------------------------------
module lbhs_cfg_regs (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_index,
  input  logic [31:0]    cfg_wdata,
  output lbhs_pkg::cfg_t cfg
);
  import lbhs_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Register write decode; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_BAND_COUNT: cfg_nxt.band_count          = cfg_wdata[2:0];
        REG_THRESH0:    cfg_nxt.threshold_band0     = cfg_wdata;
        REG_THRESH1:    cfg_nxt.threshold_band1     = cfg_wdata;
        REG_THRESH2:    cfg_nxt.threshold_band2     = cfg_wdata;
        REG_HYST:       cfg_nxt.hysteresis_fraction = cfg_wdata[16:0];
        REG_DWELL:      cfg_nxt.dwell_frames        = cfg_wdata[7:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.band_count          <= 3'd4;
      cfg_r.threshold_band0     <= 32'd65536;
      cfg_r.threshold_band1     <= 32'd131072;
      cfg_r.threshold_band2     <= 32'd262144;
      cfg_r.hysteresis_fraction <= 17'd6554;
      cfg_r.dwell_frames        <= 8'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/lbhs_decide.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbhs_decide
// One-pass band decision: clamp, threshold ladder, floor, dead-zone check
// with a single edge multiply, dwell counting and next-state selection.
// ----------------------------------------------------------------------------
module lbhs_decide (
  input  lbhs_pkg::cfg_t       cfg,
  input  lbhs_pkg::sel_state_t state_cur,
  input  lbhs_pkg::in_item_t   item,
  output lbhs_pkg::sel_state_t state_nxt,
  output lbhs_pkg::out_item_t  result
);
  import lbhs_pkg::*;

  logic [2:0]        n_use;
  logic [1:0]        last_band;
  logic [30:0]       q;
  logic [2:0][31:0]  edges;
  logic [1:0]        ladder_band;
  logic [1:0]        floor_band;
  logic [1:0]        desired;
  logic              forced_coarser;
  sel_state_t        st_fc;
  logic [1:0]        cur_clamped;
  logic              coarser;
  logic [1:0]        edge_band;
  logic [31:0]       edge_val;
  logic [16:0]       hyst;
  logic [17:0]       factor;
  logic [49:0]       product;
  logic [49:0]       lhs;
  logic              beyond;
  sel_state_t        st_upd;
  logic              changed_upd;

  // Bands in use and clamped metric
  always_comb begin
    if (cfg.band_count == 3'd0) begin
      n_use = 3'd1;
    end else if (cfg.band_count > 3'(BAND_CAP)) begin
      n_use = 3'(BAND_CAP);
    end else begin
      n_use = cfg.band_count;
    end
    last_band = 2'(n_use - 3'd1);
    q         = item.quality_metric[31] ? 31'd0 : item.quality_metric[30:0];
    edges     = {cfg.threshold_band2, cfg.threshold_band1, cfg.threshold_band0};
  end

  // Threshold ladder: first in-use band whose limit exceeds q
  always_comb begin
    logic found;
    found       = 1'b0;
    ladder_band = last_band;
    for (int i = 0; i < 3; i++) begin
      if (!found && (3'(i + 1) < n_use) && ({1'b0, q} < edges[i])) begin
        ladder_band = 2'(i);
        found       = 1'b1;
      end
    end
  end

  // Floor clamp and desired band
  always_comb begin
    floor_band = ({1'b0, item.regime_floor} < n_use) ? item.regime_floor : last_band;
    desired    = (ladder_band < floor_band) ? floor_band : ladder_band;
  end

  // Forced coarsening, then stale-band clamp
  always_comb begin
    forced_coarser = state_cur.initialized && (state_cur.current_band < floor_band);
    st_fc          = state_cur;
    if (forced_coarser) begin
      st_fc.current_band  = floor_band;
      st_fc.pending_band  = floor_band;
      st_fc.pending_count = 8'd0;
    end
    cur_clamped = (st_fc.current_band > last_band) ? last_band : st_fc.current_band;
  end

  // Dead-zone test against the shared edge
  always_comb begin
    coarser   = desired > cur_clamped;
    edge_band = coarser ? cur_clamped : desired;
    case (edge_band)
      2'd0:    edge_val = cfg.threshold_band0;
      2'd1:    edge_val = cfg.threshold_band1;
      default: edge_val = cfg.threshold_band2;
    endcase
    hyst    = (cfg.hysteresis_fraction > HYST_ONE) ? HYST_ONE : cfg.hysteresis_fraction;
    factor  = coarser ? ({1'b0, HYST_ONE} + {1'b0, hyst})
                      : ({1'b0, HYST_ONE} - {1'b0, hyst});
    product = {18'd0, edge_val} * {32'd0, factor};
    lhs     = {3'd0, q, 16'd0};
    beyond  = coarser ? (lhs >= product) : (lhs <= product);
  end

  // Update command: dwell tracking and switch
  always_comb begin
    st_upd      = st_fc;
    changed_upd = 1'b0;
    if (!state_cur.initialized) begin
      st_upd.current_band  = desired;
      st_upd.pending_band  = desired;
      st_upd.pending_count = 8'd0;
      st_upd.initialized   = 1'b1;
    end else begin
      st_upd.current_band = cur_clamped;
      if (desired != cur_clamped) begin
        if (!beyond) begin
          st_upd.pending_band  = cur_clamped;
          st_upd.pending_count = 8'd0;
        end else if (st_fc.pending_band != desired) begin
          st_upd.pending_band  = desired;
          st_upd.pending_count = 8'd1;
        end else if (st_fc.pending_count != 8'd255) begin
          st_upd.pending_count = st_fc.pending_count + 8'd1;
        end
        if (beyond && (cfg.dwell_frames <= 8'd1 ||
                       st_upd.pending_count >= cfg.dwell_frames)) begin
          st_upd.current_band  = desired;
          st_upd.pending_band  = desired;
          st_upd.pending_count = 8'd0;
          changed_upd          = 1'b1;
        end
      end else begin
        st_upd.pending_band  = cur_clamped;
        st_upd.pending_count = 8'd0;
      end
    end
    if (forced_coarser) begin
      changed_upd = 1'b1;
    end
  end

  // Command select
  always_comb begin
    state_nxt           = state_cur;
    result.band_changed = 1'b0;
    case (item.command)
      CMD_UPDATE: begin
        state_nxt           = st_upd;
        result.band_changed = changed_upd;
      end
      CMD_CLEAR: begin
        state_nxt = '0;
      end
      CMD_FORCE: begin
        state_nxt.current_band  = (item.forced_band > last_band) ? last_band
                                                                 : item.forced_band;
        state_nxt.pending_band  = state_nxt.current_band;
        state_nxt.pending_count = 8'd0;
        state_nxt.initialized   = 1'b1;
      end
      default: begin
        state_nxt = state_cur;
      end
    endcase
    result.band_index      = state_nxt.current_band;
    result.clamped_quality = q;
  end

endmodule

>>> rtl/lod_band_hysteresis_selector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lod_band_hysteresis_selector
// Per-frame LOD band choice from a Q16.16 quality metric, with a threshold
// ladder, regime floor, hysteresis dead zone and dwell count.
// ----------------------------------------------------------------------------
// Stages: the input register, then the decision and state update into the
//   result register. Throughput: one beat per cycle unless out_ready stalls;
//   the state loop through the ladder, the single 32x18 edge multiply and
//   the dead-zone compare is combinational.
// Reset: synchronous active low; clears both stages and the selector state,
//   and loads the default band count, thresholds, hysteresis and dwell.
module lod_band_hysteresis_selector (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lbhs_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lbhs_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_wdata
);
  import lbhs_pkg::*;

  cfg_t       cfg;
  in_item_t   s1_r;
  logic       s1_valid_r;
  logic       s1_valid_nxt;
  sel_state_t state_r;
  sel_state_t state_nxt;
  out_item_t  out_r;
  out_item_t  result;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       adv;
  logic       in_fire;

  lbhs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lbhs_decide u_decide (
    .cfg       (cfg),
    .state_cur (state_r),
    .item      (s1_r),
    .state_nxt (state_nxt),
    .result    (result)
  );

  // Handshake: stage 1 moves whenever the result slot is free or draining
  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt  = in_fire || (s1_valid_r && !adv);
    out_valid_nxt = adv || (out_valid_r && !out_ready);
  end

  // Control and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        state_r <= state_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= in_data;
    end
    if (adv) begin
      out_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // A clear beat returns the selector to its reset state
  a_clear_resets: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s1_r.command == CMD_CLEAR |=> state_r == '0)
    else $error("clear beat did not reset selector state");

  // A force beat leaves the selector initialized with no pending move
  a_force_init: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s1_r.command == CMD_FORCE |=>
      state_r.initialized && state_r.pending_count == 8'd0)
    else $error("force beat left selector uninitialized or pending");

  // A running dwell count always targets a band other than the current one
  a_pending_target: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.pending_count != 8'd0 |-> state_r.pending_band != state_r.current_band)
    else $error("dwell count running toward the current band");

  // Only update beats can flag a band change
  a_changed_update_only: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s1_r.command != CMD_UPDATE |=> !out_r.band_changed)
    else $error("band change flagged on a non-update beat");

  // Result register reports the band the state now holds
  a_band_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_r.band_index == state_r.current_band)
    else $error("result band differs from selector state");

endmodule

>>> dv/lod_band_hysteresis_selector_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lod_band_hysteresis_selector_test
// Self-checking bench for the LOD band selector. A scoreboard class keeps its
// own copy of the registers and selector state and predicts each result beat
// from the accepted input beats. Stimulus is a directed set for settings 0,
// 2, 3 and 4, then sticky near-edge random traffic, under three idle mixes.
// ----------------------------------------------------------------------------
module lod_band_hysteresis_selector_test;
  import lbhs_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int         RAND_BEATS = 165;
  localparam int         SETTINGS   = 8;
  localparam int         CYCLE_LIMIT = 400000;

  // Band selector prediction and expected result store
  class band_scoreboard;
    logic [2:0]  band_count;
    logic [31:0] thr [3];
    logic [16:0] hyst;
    logic [7:0]  dwell;
    logic [1:0]  cur_band;
    logic [1:0]  pend_band;
    logic [7:0]  pend_count;
    logic        inited;
    out_item_t   expected_bands [$];
    int          errors;

    function new();
      band_count = 3'd4;
      thr[0]     = 32'h0001_0000;
      thr[1]     = 32'h0002_0000;
      thr[2]     = 32'h0004_0000;
      hyst       = 17'd6554;
      dwell      = 8'd0;
      cur_band   = '0;
      pend_band  = '0;
      pend_count = '0;
      inited     = 1'b0;
      errors     = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_BAND_COUNT: band_count = val[2:0];
        REG_THRESH0:    thr[0] = val;
        REG_THRESH1:    thr[1] = val;
        REG_THRESH2:    thr[2] = val;
        REG_HYST:       hyst = val[16:0];
        REG_DWELL:      dwell = val[7:0];
        default: ;
      endcase
    endfunction

    function int unsigned bands_active();
      int unsigned n;
      n = band_count;
      if (n < 1) n = 1;
      if (n > BAND_CAP) n = BAND_CAP;
      return n;
    endfunction

    // first band whose threshold lies above q; last band is unbounded
    function int unsigned ladder_band(logic [31:0] q, int unsigned n);
      for (int i = 0; i + 1 < n; i++)
        if (q < thr[i]) return i;
      return n - 1;
    endfunction

    function void note_input(in_item_t beat);
      logic [31:0]  q;
      int unsigned  n;
      int unsigned  fl;
      int unsigned  desired;
      logic         forced_coarser;
      logic         coarser;
      logic         beyond;
      logic         changed;
      logic [63:0]  edge_v;
      logic [63:0]  h;
      logic [63:0]  lhs;
      out_item_t    e;
      q       = beat.quality_metric[31] ? 32'd0 : beat.quality_metric;
      n       = bands_active();
      changed = 1'b0;
      case (beat.command)
        CMD_CLEAR: begin
          cur_band   = '0;
          pend_band  = '0;
          pend_count = '0;
          inited     = 1'b0;
        end
        CMD_FORCE: begin
          cur_band   = 2'((beat.forced_band < n) ? beat.forced_band : n - 1);
          pend_band  = cur_band;
          pend_count = '0;
          inited     = 1'b1;
        end
        CMD_UPDATE: begin
          fl      = (beat.regime_floor < n) ? beat.regime_floor : n - 1;
          desired = ladder_band(q, n);
          if (desired < fl) desired = fl;
          // floor above the current band coarsens at once
          forced_coarser = inited && (cur_band < fl);
          if (forced_coarser) begin
            cur_band   = 2'(fl);
            pend_band  = 2'(fl);
            pend_count = '0;
          end
          if (!inited) begin
            cur_band   = 2'(desired);
            pend_band  = 2'(desired);
            pend_count = '0;
            inited     = 1'b1;
          end else begin
            // stale band after the count shrinks
            if (cur_band > n - 1) cur_band = 2'(n - 1);
            if (desired != cur_band) begin
              coarser = desired > cur_band;
              edge_v  = {32'd0, thr[coarser ? cur_band : desired]};
              h       = (hyst > HYST_ONE) ? 64'd65536 : {47'd0, hyst};
              lhs     = {16'd0, q, 16'd0};
              beyond  = coarser ? (lhs >= edge_v * (64'd65536 + h))
                                : (lhs <= edge_v * (64'd65536 - h));
              if (!beyond) begin
                pend_band  = cur_band;
                pend_count = '0;
              end else if (pend_band != desired) begin
                pend_band  = 2'(desired);
                pend_count = 8'd1;
              end else if (pend_count < 8'd255) begin
                pend_count = pend_count + 8'd1;
              end
              if (beyond && (dwell <= 8'd1 || pend_count >= dwell)) begin
                cur_band   = 2'(desired);
                pend_band  = 2'(desired);
                pend_count = '0;
                changed    = 1'b1;
              end
            end else begin
              pend_band  = cur_band;
              pend_count = '0;
            end
          end
          if (forced_coarser) changed = 1'b1;
        end
        default: ;
      endcase
      e.band_index      = cur_band;
      e.band_changed    = changed;
      e.clamped_quality = q[30:0];
      expected_bands.push_back(e);
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (expected_bands.size() == 0) begin
        $error("result beat with no expected band waiting");
        errors++;
        return;
      end
      e = expected_bands.pop_front();
      if (got.band_index !== e.band_index) begin
        $error("band_index mismatch: expected %0d, actual %0d", e.band_index, got.band_index);
        errors++;
      end
      if (got.band_changed !== e.band_changed) begin
        $error("band_changed mismatch: expected %0d, actual %0d",
               e.band_changed, got.band_changed);
        errors++;
      end
      if (got.clamped_quality !== e.clamped_quality) begin
        $error("clamped_quality mismatch: expected 0x%08h, actual 0x%08h",
               e.clamped_quality, got.clamped_quality);
        errors++;
      end
    endfunction

    function int outstanding();
      return expected_bands.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  band_scoreboard sb = new();

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned beats_in = 0;
  int unsigned beats_out = 0;
  int unsigned cycles = 0;
  logic [31:0] reg_plan [6];
  logic [31:0] q_target = '0;

  lod_band_hysteresis_selector uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // receiver backpressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // beat monitor: note accepted inputs, check accepted results
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sb.note_input(in_data);
        beats_in++;
      end
      if (out_valid && out_ready) begin
        sb.check_result(out_data);
        beats_out++;
      end
    end
  end

  // run watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.outstanding());
      $display("FAIL lod_band_hysteresis_selector");
      $finish;
    end
  end

  // one input beat, with random sender gaps ahead of it
  task automatic send_beat(input in_item_t beat);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_cmd(input logic [1:0] cmd, input logic [31:0] q,
                          input logic [1:0] fl, input logic [1:0] forced);
    in_item_t beat;
    beat.command        = cmd;
    beat.quality_metric = q;
    beat.regime_floor   = fl;
    beat.forced_band    = forced;
    send_beat(beat);
  endtask

  // let the pipe empty before touching registers
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic program_regs();
    for (int r = REG_BAND_COUNT; r <= REG_DWELL; r++) begin
      cfg_we    <= 1'b1;
      cfg_index <= r[2:0];
      cfg_wdata <= reg_plan[r];
      sb.write_reg(r[2:0], reg_plan[r]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic apply_setting(input int s);
    logic [31:0] t0;
    case (s)
      1: begin
        reg_plan[REG_BAND_COUNT] = 32'd2;
        reg_plan[REG_THRESH0]    = 32'h0003_0000;
        reg_plan[REG_THRESH1]    = 32'h0001_8000;
        reg_plan[REG_THRESH2]    = 32'h0010_0000;
        reg_plan[REG_HYST]       = 32'd0;
        reg_plan[REG_DWELL]      = 32'd1;
      end
      2: begin
        reg_plan[REG_BAND_COUNT] = 32'd4;
        reg_plan[REG_THRESH0]    = 32'h0001_0000;
        reg_plan[REG_THRESH1]    = 32'h0003_0000;
        reg_plan[REG_THRESH2]    = 32'h0008_0000;
        reg_plan[REG_HYST]       = 32'd16384;
        reg_plan[REG_DWELL]      = 32'd3;
      end
      3: begin
        reg_plan[REG_BAND_COUNT] = 32'd1;
        reg_plan[REG_THRESH0]    = 32'h7FFF_FFFF;
        reg_plan[REG_THRESH1]    = 32'd0;
        reg_plan[REG_THRESH2]    = 32'd0;
        reg_plan[REG_HYST]       = 32'd65536;
        reg_plan[REG_DWELL]      = 32'd255;
      end
      4: begin
        reg_plan[REG_BAND_COUNT] = 32'd7;
        reg_plan[REG_THRESH0]    = 32'd0;
        reg_plan[REG_THRESH1]    = 32'h7FFF_FFFF;
        reg_plan[REG_THRESH2]    = 32'hFFFF_FFFF;
        reg_plan[REG_HYST]       = 32'h0001_FFFF;
        reg_plan[REG_DWELL]      = 32'd255;
      end
      5: begin
        // thresholds in no particular order
        reg_plan[REG_BAND_COUNT] = 32'd3;
        reg_plan[REG_THRESH0]    = $urandom_range(0, 32'h0008_0000);
        reg_plan[REG_THRESH1]    = $urandom_range(0, 32'h0008_0000);
        reg_plan[REG_THRESH2]    = $urandom_range(0, 32'h0008_0000);
        reg_plan[REG_HYST]       = $urandom_range(0, 32'h0001_FFFF);
        reg_plan[REG_DWELL]      = $urandom_range(0, 8);
      end
      6: begin
        reg_plan[REG_BAND_COUNT] = 32'd0;
        reg_plan[REG_THRESH0]    = $urandom();
        reg_plan[REG_THRESH1]    = $urandom();
        reg_plan[REG_THRESH2]    = $urandom();
        reg_plan[REG_HYST]       = 32'd65535;
        reg_plan[REG_DWELL]      = 32'd2;
      end
      default: begin
        t0 = $urandom_range(32'h4000, 32'h0002_0000);
        reg_plan[REG_BAND_COUNT] = 32'd5;
        reg_plan[REG_THRESH0]    = t0;
        reg_plan[REG_THRESH1]    = t0 + $urandom_range(0, 32'h0002_0000);
        reg_plan[REG_THRESH2]    = t0 + $urandom_range(32'h0002_0000, 32'h0006_0000);
        reg_plan[REG_HYST]       = $urandom_range(0, 20000);
        reg_plan[REG_DWELL]      = $urandom_range(0, 5);
      end
    endcase
    program_regs();
  endtask

  // directed beats for the setting just programmed
  task automatic directed_beats(input int s);
    case (s)
      0: begin
        send_cmd(CMD_UPDATE, 32'd0, 2'd0, 2'd0);          // first update adopts
        send_cmd(CMD_UPDATE, 32'd72089, 2'd0, 2'd0);      // inside dead zone
        send_cmd(CMD_UPDATE, 32'd72090, 2'd0, 2'd0);      // just past it
        send_cmd(CMD_UPDATE, 32'd58983, 2'd0, 2'd0);
        send_cmd(CMD_UPDATE, 32'd58982, 2'd0, 2'd0);
        send_cmd(CMD_UPDATE, 32'h7FFF_FFFF, 2'd0, 2'd3);
        send_cmd(CMD_UPDATE, 32'h8000_0000, 2'd0, 2'd3);  // most negative
        send_cmd(CMD_UPDATE, 32'hFFFF_FFFF, 2'd2, 2'd0);  // floor coarsens
        send_cmd(CMD_UPDATE, 32'd0, 2'd3, 2'd0);
        send_cmd(CMD_FORCE, 32'd12345, 2'd0, 2'd1);
        send_cmd(CMD_UNUSED, 32'hDEAD_BEEF, 2'd3, 2'd3);
        send_cmd(CMD_CLEAR, 32'h7FFF_FFFF, 2'd3, 2'd3);
        send_cmd(CMD_UPDATE, 32'd300000, 2'd1, 2'd0);
        send_cmd(CMD_FORCE, 32'hFFFF_0000, 2'd0, 2'd3);
        send_cmd(CMD_UPDATE, 32'h7FFF_FFFF, 2'd3, 2'd2);
      end
      2: begin
        // dwell of three, then an interrupted run, then a change of target
        send_cmd(CMD_CLEAR, 32'd0, 2'd0, 2'd0);
        send_cmd(CMD_UPDATE, 32'd0, 2'd0, 2'd0);
        repeat (3) send_cmd(CMD_UPDATE, 32'd90000, 2'd0, 2'd0);
        send_cmd(CMD_UPDATE, 32'd40000, 2'd0, 2'd0);
        send_cmd(CMD_UPDATE, 32'd40000, 2'd0, 2'd0);
        send_cmd(CMD_UPDATE, 32'd70000, 2'd0, 2'd0);
        repeat (3) send_cmd(CMD_UPDATE, 32'd40000, 2'd0, 2'd0);
        send_cmd(CMD_UPDATE, 32'd90000, 2'd0, 2'd0);
        repeat (3) send_cmd(CMD_UPDATE, 32'h7FFF_FFFF, 2'd0, 2'd0);
      end
      3: begin
        // band left at three from the last setting, count now one
        send_cmd(CMD_UPDATE, 32'd5, 2'd3, 2'd0);
        send_cmd(CMD_FORCE, 32'd5, 2'd0, 2'd3);
        send_cmd(CMD_CLEAR, 32'd5, 2'd0, 2'd0);
        send_cmd(CMD_UPDATE, 32'hFFFF_FFFB, 2'd2, 2'd0);
      end
      4: begin
        send_cmd(CMD_CLEAR, 32'd0, 2'd0, 2'd0);
        send_cmd(CMD_UPDATE, 32'd0, 2'd0, 2'd0);
        send_cmd(CMD_UPDATE, 32'h7FFF_FFFF, 2'd0, 2'd0);
        send_cmd(CMD_UPDATE, 32'd0, 2'd0, 2'd0);
        send_cmd(CMD_UPDATE, 32'd0, 2'd3, 2'd0);
      end
      default: ;
    endcase
  endtask

  // random beat: mostly updates around a sticky target near the band edges
  function automatic in_item_t random_beat();
    in_item_t    beat;
    logic [31:0] e;
    logic [63:0] span;
    int unsigned pick;
    if ($urandom_range(0, 99) < 25) begin
      pick = $urandom_range(0, 3);
      if (pick < 2) begin
        e    = sb.thr[$urandom_range(0, 2)];
        span = ({32'd0, e} * {47'd0, sb.hyst}) >> 16;
        q_target = pick[0] ? e + span[31:0] : e - span[31:0];
      end else if (pick == 2) begin
        q_target = $urandom();
      end else begin
        q_target = $urandom_range(0, 32'h0010_0000);
      end
    end
    beat.quality_metric = q_target + $urandom_range(0, 31) - 32'd16;
    pick = $urandom_range(0, 99);
    if (pick < 86) beat.command = CMD_UPDATE;
    else if (pick < 91) beat.command = CMD_FORCE;
    else if (pick < 95) beat.command = CMD_CLEAR;
    else beat.command = CMD_UNUSED;
    beat.regime_floor = ($urandom_range(0, 99) < 70) ? 2'd0 : 2'($urandom_range(0, 3));
    beat.forced_band  = 2'($urandom_range(0, 3));
    return beat;
  endfunction

  task automatic random_beats(input int count);
    repeat (count) send_beat(random_beat());
    // park on the top band so the next setting starts from a known band
    send_cmd(CMD_FORCE, $urandom(), 2'd0, 2'd3);
  endtask

  // main sequence
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int s = 0; s < SETTINGS; s++) begin
      if (s < 3) begin
        send_idle_pct = 24;
        recv_idle_pct = 57;
      end else if (s < 6) begin
        send_idle_pct = 57;
        recv_idle_pct = 24;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (s > 0) begin
        drain();
        apply_setting(s);
      end
      directed_beats(s);
      random_beats(RAND_BEATS);
    end
    drain();
    repeat (8) @(posedge clk);
    $display("Ran %0d input beats and %0d result beats across %0d register settings,",
             beats_in, beats_out, SETTINGS);
    $display("covering dead-zone edges, dwell runs, floors, clears, forces and stalls.");
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("PASS lod_band_hysteresis_selector");
    end else begin
      $display("FAIL lod_band_hysteresis_selector");
    end
    $finish;
  end

endmodule
